// File: sv/xfp_pkg.sv
`timescale 1ns / 1ps
package xfp_pkg;

   // Frame geometry
   localparam int MAX_PAYLOAD = 32;
   localparam int LEN_W       = 6;
   localparam int IDX_W       = 5;
   localparam int CNT_W       = 16;
   localparam logic [7:0] LEN_LIMIT = 8'(MAX_PAYLOAD);

   // CSR port
   localparam int ADDR_W = 4;
   localparam int DATA_W = 32;
   localparam logic [1:0] REG_START_BYTE   = 2'd0;
   localparam logic [1:0] REG_COMMAND_TYPE = 2'd1;
   localparam logic [1:0] REG_COMMAND_LEN  = 2'd2;
   localparam logic [1:0] REG_TIMEOUT      = 2'd3;

   // Result kinds
   localparam logic [1:0] KIND_BYTE   = 2'd0;
   localparam logic [1:0] KIND_EMPTY  = 2'd1;
   localparam logic [1:0] KIND_FAIL   = 2'd2;
   localparam logic [1:0] KIND_REJECT = 2'd3;

   typedef struct packed {
      logic [7:0]       start_byte;
      logic [7:0]       command_type;
      logic [LEN_W-1:0] command_length;
      logic [CNT_W-1:0] timeout_ticks;
   } cfg_type;

   // Sequencer -> datapath
   typedef struct packed {
      logic load_in;   // capture the request
      logic exec;      // apply the request to parser and timer state
      logic rd;        // read the payload store at the run index
      logic put;       // load one payload result, advance the run index
   } cmd_type;

   // Datapath -> sequencer
   typedef struct packed {
      logic ev_single; // request yields exactly one result
      logic ev_run;    // request yields a payload run
      logic run_last;  // run index is at the final payload byte
      logic out_free;  // result register can take a new result
   } sts_type;

endpackage

// File: sv/xfp_csr.sv
`timescale 1ns / 1ps
module xfp_csr (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [xfp_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [xfp_pkg::DATA_W-1:0] csr_pwdata,
   output logic [xfp_pkg::DATA_W-1:0] csr_prdata,
   output logic                      csr_pready,
   output xfp_pkg::cfg_type          cfg
);
   import xfp_pkg::*;

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte     <= 8'd170;
         cfg_ff.command_type   <= 8'd1;
         cfg_ff.command_length <= LEN_W'(8);
         cfg_ff.timeout_ticks  <= CNT_W'(500);
      end else if (wr_en) begin
         case (reg_idx)
            REG_START_BYTE:   cfg_ff.start_byte     <= csr_pwdata[7:0];
            REG_COMMAND_TYPE: cfg_ff.command_type   <= csr_pwdata[7:0];
            REG_COMMAND_LEN:  cfg_ff.command_length <= csr_pwdata[LEN_W-1:0];
            REG_TIMEOUT:      cfg_ff.timeout_ticks  <= csr_pwdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_START_BYTE:   csr_prdata = DATA_W'(cfg_ff.start_byte);
         REG_COMMAND_TYPE: csr_prdata = DATA_W'(cfg_ff.command_type);
         REG_COMMAND_LEN:  csr_prdata = DATA_W'(cfg_ff.command_length);
         REG_TIMEOUT:      csr_prdata = DATA_W'(cfg_ff.timeout_ticks);
         default:          csr_prdata = '0;
      endcase
   end

endmodule

// File: sv/xfp_ctrl.sv
`timescale 1ns / 1ps
module xfp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  xfp_pkg::sts_type  sts,
   output xfp_pkg::cmd_type  cmd
);
   import xfp_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_READ = 4'b0100,
      ST_PUT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // hold while a single result has nowhere to go
            if (!sts.ev_single || sts.out_free) begin
               cmd.exec = 1'b1;
               state_in = sts.ev_run ? ST_READ : ST_IDLE;
            end
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_PUT;
         end
         ST_PUT: begin
            if (sts.out_free) begin
               cmd.put  = 1'b1;
               state_in = sts.run_last ? ST_IDLE : ST_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: sv/xfp_dp.sv
`timescale 1ns / 1ps
module xfp_dp (
   input  logic                       clock,
   input  logic                       reset,
   input  xfp_pkg::cfg_type           cfg,
   input  xfp_pkg::cmd_type           cmd,
   output xfp_pkg::sts_type           sts,
   input  logic                       req_func,
   input  logic [7:0]                 req_data_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [1:0]                 rsp_kind,
   output logic [7:0]                 rsp_frame_type,
   output logic [xfp_pkg::LEN_W-1:0]  rsp_frame_length,
   output logic [xfp_pkg::IDX_W-1:0]  rsp_byte_index,
   output logic [7:0]                 rsp_payload_byte,
   output logic                       rsp_is_command,
   output logic                       rsp_failsafe_now,
   output logic                       rsp_last
);
   import xfp_pkg::*;

   typedef enum logic [4:0] {
      PH_WAIT  = 5'b00001,
      PH_TYPE  = 5'b00010,
      PH_LEN   = 5'b00100,
      PH_DATA  = 5'b01000,
      PH_CHECK = 5'b10000
   } phase_type;

   // Held request
   logic             func_ff;
   logic [7:0]       byte_ff;

   // Parser and timer state
   phase_type        phase_ff, phase_in;
   logic [7:0]       type_ff, type_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] count_ff, count_in;
   logic [7:0]       xor_ff, xor_in;
   logic [CNT_W-1:0] ticks_ff, ticks_in;
   logic             fs_ff, fs_in;
   logic             cmdf_ff, cmdf_in;

   // Payload store and run
   logic [7:0]       mem [MAX_PAYLOAD];
   logic             mem_wr;
   logic [7:0]       rd_ff;
   logic [IDX_W-1:0] idx_ff;

   // Result register
   logic             ov_ff;
   logic [1:0]       kind_ff, kind_in;
   logic [7:0]       otype_ff, otype_in;
   logic [LEN_W-1:0] olen_ff, olen_in;
   logic [IDX_W-1:0] oidx_ff;
   logic [7:0]       obyte_ff;
   logic             ocmd_ff, ocmd_in;
   logic             ofs_ff;
   logic             olast_ff;

   logic [CNT_W-1:0] ticks_inc;
   logic             fs_enter, len_bad, at_check, sum_ok, is_cmd_now;
   logic [LEN_W-1:0] count_inc;

   assign ticks_inc  = (ticks_ff != '1) ? ticks_ff + CNT_W'(1) : ticks_ff;
   assign fs_enter   = func_ff && !fs_ff && (ticks_inc > cfg.timeout_ticks);
   assign len_bad    = !func_ff && (phase_ff == PH_LEN) && (byte_ff > LEN_LIMIT);
   assign at_check   = !func_ff && (phase_ff == PH_CHECK);
   assign sum_ok     = (byte_ff == xor_ff);
   assign is_cmd_now = (type_ff == cfg.command_type) && (len_ff == cfg.command_length);
   assign count_inc  = count_ff + LEN_W'(1);

   assign sts.ev_single = fs_enter || len_bad ||
                          (at_check && (!sum_ok || (len_ff == '0)));
   assign sts.ev_run    = at_check && sum_ok && (len_ff != '0);
   assign sts.run_last  = ({1'b0, idx_ff} == len_ff - LEN_W'(1));
   assign sts.out_free  = !ov_ff || !rsp_stall;

   // Next parser/timer state for the held request
   always_comb begin
      phase_in = phase_ff;
      type_in  = type_ff;
      len_in   = len_ff;
      count_in = count_ff;
      xor_in   = xor_ff;
      ticks_in = ticks_ff;
      fs_in    = fs_ff;
      cmdf_in  = cmdf_ff;
      mem_wr   = 1'b0;
      if (func_ff) begin
         ticks_in = ticks_inc;
         if (fs_enter) fs_in = 1'b1;
      end else begin
         case (phase_ff)
            PH_TYPE: begin
               type_in  = byte_ff;
               phase_in = PH_LEN;
            end
            PH_LEN: begin
               if (len_bad) begin
                  phase_in = PH_WAIT;
               end else begin
                  len_in   = byte_ff[LEN_W-1:0];
                  count_in = '0;
                  xor_in   = type_ff ^ byte_ff;
                  phase_in = (byte_ff != 8'd0) ? PH_DATA : PH_CHECK;
               end
            end
            PH_DATA: begin
               mem_wr   = 1'b1;
               xor_in   = xor_ff ^ byte_ff;
               count_in = count_inc;
               if (count_inc >= len_ff) phase_in = PH_CHECK;
            end
            PH_CHECK: begin
               phase_in = PH_WAIT;
               if (sum_ok) begin
                  cmdf_in = is_cmd_now;
                  if (is_cmd_now) begin
                     ticks_in = '0;
                     fs_in    = 1'b0;
                  end
               end
            end
            default: phase_in = (byte_ff == cfg.start_byte) ? PH_TYPE : PH_WAIT;
         endcase
      end
   end

   // Single-result fields
   always_comb begin
      if (fs_enter) begin
         kind_in  = KIND_FAIL;
         otype_in = 8'd0;
         olen_in  = '0;
         ocmd_in  = 1'b0;
      end else if (len_bad) begin
         kind_in  = KIND_REJECT;
         otype_in = type_ff;
         olen_in  = '0;
         ocmd_in  = 1'b0;
      end else if (!sum_ok) begin
         kind_in  = KIND_REJECT;
         otype_in = type_ff;
         olen_in  = len_ff;
         ocmd_in  = 1'b0;
      end else begin
         kind_in  = KIND_EMPTY;
         otype_in = type_ff;
         olen_in  = '0;
         ocmd_in  = is_cmd_now;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         func_ff <= req_func;
         byte_ff <= req_data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         type_ff  <= '0;
         len_ff   <= '0;
         count_ff <= '0;
         xor_ff   <= '0;
         ticks_ff <= '0;
         fs_ff    <= 1'b0;
         cmdf_ff  <= 1'b0;
      end else if (cmd.exec) begin
         phase_ff <= phase_in;
         type_ff  <= type_in;
         len_ff   <= len_in;
         count_ff <= count_in;
         xor_ff   <= xor_in;
         ticks_ff <= ticks_in;
         fs_ff    <= fs_in;
         cmdf_ff  <= cmdf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && mem_wr) mem[count_ff[IDX_W-1:0]] <= byte_ff;
      if (cmd.rd) rd_ff <= mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         idx_ff <= '0;
      end else if (cmd.put) begin
         idx_ff <= idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if ((cmd.exec && sts.ev_single) || cmd.put) begin
         ov_ff <= 1'b1;
      end else if (!rsp_stall) begin
         ov_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && sts.ev_single) begin
         kind_ff  <= kind_in;
         otype_ff <= otype_in;
         olen_ff  <= olen_in;
         oidx_ff  <= '0;
         obyte_ff <= 8'd0;
         ocmd_ff  <= ocmd_in;
         ofs_ff   <= fs_in;
         olast_ff <= 1'b1;
      end else if (cmd.put) begin
         kind_ff  <= KIND_BYTE;
         otype_ff <= type_ff;
         olen_ff  <= len_ff;
         oidx_ff  <= idx_ff;
         obyte_ff <= rd_ff;
         ocmd_ff  <= cmdf_ff;
         ofs_ff   <= fs_ff;
         olast_ff <= sts.run_last;
      end
   end

   assign rsp_valid        = ov_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_frame_type   = otype_ff;
   assign rsp_frame_length = olen_ff;
   assign rsp_byte_index   = oidx_ff;
   assign rsp_payload_byte = obyte_ff;
   assign rsp_is_command   = ocmd_ff;
   assign rsp_failsafe_now = ofs_ff;
   assign rsp_last         = olast_ff;

endmodule

// File: sv/xor_frame_parser_with_failsafe_top.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake          | Payload
// req_    | in        | req_valid/stall    | func, data_byte
// rsp_    | out       | rsp_valid/stall    | kind, frame_type, frame_length, byte_index,
//         |           |                    | payload_byte, is_command, failsafe_now, last
// csr_    | in        | psel/penable/pready| paddr, pwdata, prdata (4 registers)
//
// A request is captured in the idle state and applied in the exec state, which
// holds while a single result has nowhere to go. A good frame streams each of
// its payload bytes as one read of the single-port payload store (read state)
// and one load of the result register (put state).
// Synchronous active-high reset returns the parser to waiting for the start byte,
// clears the tick counter and failsafe flag and loads the register defaults.
// A stalled result holds the sequencer; the request side waits meanwhile.
module xor_frame_parser_with_failsafe_top (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_func,
   input  logic [7:0]                 req_data_byte,
   // result channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [1:0]                 rsp_kind,
   output logic [7:0]                 rsp_frame_type,
   output logic [xfp_pkg::LEN_W-1:0]  rsp_frame_length,
   output logic [xfp_pkg::IDX_W-1:0]  rsp_byte_index,
   output logic [7:0]                 rsp_payload_byte,
   output logic                       rsp_is_command,
   output logic                       rsp_failsafe_now,
   output logic                       rsp_last,
   // register port
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [xfp_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [xfp_pkg::DATA_W-1:0] csr_pwdata,
   output logic [xfp_pkg::DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);
   import xfp_pkg::*;

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;

   // Registers: start byte, command type/length, tick timeout
   xfp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Sequencer: take request, apply it, then stream any payload run
   xfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Deframer state, tick counter, payload store and result register
   xfp_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .cmd              (cmd),
      .sts              (sts),
      .req_func         (req_func),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_frame_type   (rsp_frame_type),
      .rsp_frame_length (rsp_frame_length),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_is_command   (rsp_is_command),
      .rsp_failsafe_now (rsp_failsafe_now),
      .rsp_last         (rsp_last)
   );

endmodule

// File: sv/xfp_chk.sv
`timescale 1ns / 1ps
module xfp_chk (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [1:0]                 rsp_kind,
   input logic [xfp_pkg::LEN_W-1:0]  rsp_frame_length,
   input logic [xfp_pkg::IDX_W-1:0]  rsp_byte_index,
   input logic                       rsp_failsafe_now,
   input logic                       rsp_last
);
   import xfp_pkg::*;

   // Stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // One request at a time: busy right after a request is taken
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one in flight");

   // Failsafe report carries the raised flag
   a_fail_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_FAIL) |-> rsp_failsafe_now)
      else $error("failsafe result without flag");

   // Non-payload results are single-result runs
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != KIND_BYTE) |-> rsp_last)
      else $error("single result without last");

   // Payload index stays inside the frame, last on the final byte
   a_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_BYTE) |->
         ({1'b0, rsp_byte_index} < rsp_frame_length) &&
         (rsp_last == ({1'b0, rsp_byte_index} == rsp_frame_length - LEN_W'(1))))
      else $error("payload index or last mark out of place");

endmodule

bind xor_frame_parser_with_failsafe_top xfp_chk u_chk (.*);

// File: verif/xfp_frame_checker.sv
`timescale 1ns / 1ps
module xfp_frame_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic                       req_func,
   input  logic [7:0]                 req_data_byte,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic [1:0]                 rsp_kind,
   input  logic [7:0]                 rsp_frame_type,
   input  logic [xfp_pkg::LEN_W-1:0]  rsp_frame_length,
   input  logic [xfp_pkg::IDX_W-1:0]  rsp_byte_index,
   input  logic [7:0]                 rsp_payload_byte,
   input  logic                       rsp_is_command,
   input  logic                       rsp_failsafe_now,
   input  logic                       rsp_last,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [xfp_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [xfp_pkg::DATA_W-1:0] csr_pwdata,
   input  logic                       csr_pready,
   output int                         mismatches,
   output int                         results_pending,
   output int                         results_checked
);
   import xfp_pkg::*;

   typedef enum logic [4:0] {
      SEEK_START   = 5'b00001,
      GET_TYPE     = 5'b00010,
      GET_LENGTH   = 5'b00100,
      GET_PAYLOAD  = 5'b01000,
      GET_CHECKSUM = 5'b10000
   } parse_phase_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic [7:0]       frame_type;
      logic [LEN_W-1:0] frame_length;
      logic [IDX_W-1:0] byte_index;
      logic [7:0]       payload_byte;
      logic             is_command;
      logic             failsafe_now;
      logic             last;
   } frame_result_type;

   cfg_type          settings;
   parse_phase_type  phase;
   logic [7:0]       type_seen;
   logic [LEN_W-1:0] length_seen;
   logic [LEN_W-1:0] bytes_seen;
   logic [7:0]       payload_copy [MAX_PAYLOAD];
   logic [7:0]       checksum_acc;
   logic [CNT_W-1:0] idle_ticks;
   logic             failsafe;
   frame_result_type results_due [$];
   int               error_count = 0;
   int               checked_count = 0;

   function automatic void expect_result(logic [1:0] kind, logic [7:0] mtype,
         logic [LEN_W-1:0] len, logic [IDX_W-1:0] idx, logic [7:0] value,
         logic cmd, logic last);
      frame_result_type r;
      r = '{kind, mtype, len, idx, value, cmd, failsafe, last};
      results_due.push_back(r);
   endfunction

   function automatic string describe(frame_result_type r);
      return $sformatf("kind %0d type %02h len %0d idx %0d byte %02h cmd %b fs %b last %b",
                       r.kind, r.frame_type, r.frame_length, r.byte_index,
                       r.payload_byte, r.is_command, r.failsafe_now, r.last);
   endfunction

   function automatic void close_frame(logic [7:0] check);
      logic cmd;
      int   i;
      phase = SEEK_START;
      if (check != checksum_acc) begin
         expect_result(KIND_REJECT, type_seen, length_seen, '0, '0, 1'b0, 1'b1);
         return;
      end
      cmd = (type_seen == settings.command_type) &&
            (length_seen == settings.command_length);
      // a command frame restarts the timeout and leaves failsafe
      if (cmd) begin
         idle_ticks = '0;
         failsafe   = 1'b0;
      end
      if (length_seen == '0)
         expect_result(KIND_EMPTY, type_seen, '0, '0, '0, cmd, 1'b1);
      else
         for (i = 0; i < int'(length_seen); i++)
            expect_result(KIND_BYTE, type_seen, length_seen, IDX_W'(i),
                          payload_copy[i], cmd, (i + 1) == int'(length_seen));
   endfunction

   function automatic void take_byte(logic [7:0] b);
      case (phase)
         GET_TYPE: begin
            type_seen = b;
            phase     = GET_LENGTH;
         end
         GET_LENGTH: begin
            if (b > LEN_LIMIT) begin
               phase = SEEK_START;
               expect_result(KIND_REJECT, type_seen, '0, '0, '0, 1'b0, 1'b1);
            end else begin
               length_seen  = b[LEN_W-1:0];
               bytes_seen   = '0;
               checksum_acc = type_seen ^ b;
               phase        = (b != 8'd0) ? GET_PAYLOAD : GET_CHECKSUM;
            end
         end
         GET_PAYLOAD: begin
            payload_copy[bytes_seen[IDX_W-1:0]] = b;
            checksum_acc ^= b;
            bytes_seen   += 1'b1;
            if (bytes_seen >= length_seen) phase = GET_CHECKSUM;
         end
         GET_CHECKSUM: close_frame(b);
         default: phase = (b == settings.start_byte) ? GET_TYPE : SEEK_START;
      endcase
   endfunction

   function automatic void take_tick();
      if (idle_ticks != '1) idle_ticks += 1'b1;
      if (!failsafe && idle_ticks > settings.timeout_ticks) begin
         failsafe = 1'b1;
         expect_result(KIND_FAIL, '0, '0, '0, '0, 1'b0, 1'b1);
      end
   endfunction

   always @(posedge clock) begin
      frame_result_type got;
      frame_result_type want;
      if (reset) begin
         settings.start_byte     = 8'd170;
         settings.command_type   = 8'd1;
         settings.command_length = LEN_W'(8);
         settings.timeout_ticks  = CNT_W'(500);
         phase        = SEEK_START;
         type_seen    = '0;
         length_seen  = '0;
         bytes_seen   = '0;
         checksum_acc = '0;
         idle_ticks   = '0;
         failsafe     = 1'b0;
         results_due.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[ADDR_W-1:2])
               REG_START_BYTE:   settings.start_byte     = csr_pwdata[7:0];
               REG_COMMAND_TYPE: settings.command_type   = csr_pwdata[7:0];
               REG_COMMAND_LEN:  settings.command_length = csr_pwdata[LEN_W-1:0];
               REG_TIMEOUT:      settings.timeout_ticks  = csr_pwdata[CNT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if (req_func) take_tick();
            else take_byte(req_data_byte);
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_kind, rsp_frame_type, rsp_frame_length, rsp_byte_index,
                    rsp_payload_byte, rsp_is_command, rsp_failsafe_now, rsp_last};
            if (results_due.size() == 0) begin
               if (error_count < 10) $display("unexpected result: %s", describe(got));
               error_count++;
            end else begin
               want = results_due.pop_front();
               if (got !== want) begin
                  if (error_count < 10) begin
                     $display("mismatch at result %0d", checked_count);
                     $display("  expected %s", describe(want));
                     $display("  actual   %s", describe(got));
                  end
                  error_count++;
               end
               checked_count++;
            end
         end
      end
      mismatches      <= error_count;
      results_pending <= results_due.size();
      results_checked <= checked_count;
   end

endmodule

// File: verif/tb_xor_frame_parser_with_failsafe_top.sv
`timescale 1ns / 1ps
module tb_xor_frame_parser_with_failsafe_top;
   import xfp_pkg::*;

   // Generous ceiling: a few hundred requests, each after the longest gap and
   // followed by a 32-byte run under the longest stalls, times several.
   localparam int CYCLE_LIMIT = 1_000_000;

   // Request function codes
   localparam logic FUNC_BYTE = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic              req_func;
   logic [7:0]        req_data_byte;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [1:0]        rsp_kind;
   logic [7:0]        rsp_frame_type;
   logic [LEN_W-1:0]  rsp_frame_length;
   logic [IDX_W-1:0]  rsp_byte_index;
   logic [7:0]        rsp_payload_byte;
   logic              rsp_is_command;
   logic              rsp_failsafe_now;
   logic              rsp_last;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [ADDR_W-1:0] csr_paddr;
   logic [DATA_W-1:0] csr_pwdata;
   logic [DATA_W-1:0] csr_prdata;
   logic              csr_pready;

   int      mismatches;
   int      results_pending;
   int      results_checked;
   int      cycle_count = 0;
   int      requests_sent = 0;
   int      ticks_sent = 0;
   int      noise_sent = 0;
   int      settings_used = 0;
   bit      calm = 1'b0;      // when set, neither side inserts idle cycles
   cfg_type active_cfg;      // mirror of what was last written to the block

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   xor_frame_parser_with_failsafe_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_frame_type   (rsp_frame_type),
      .rsp_frame_length (rsp_frame_length),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_is_command   (rsp_is_command),
      .rsp_failsafe_now (rsp_failsafe_now),
      .rsp_last         (rsp_last),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   // The checker mirrors the parser and the tick timer, snoops register writes
   // and compares every result against its own prediction.
   xfp_frame_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_frame_type   (rsp_frame_type),
      .rsp_frame_length (rsp_frame_length),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_is_command   (rsp_is_command),
      .rsp_failsafe_now (rsp_failsafe_now),
      .rsp_last         (rsp_last),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_pready       (csr_pready),
      .mismatches       (mismatches),
      .results_pending  (results_pending),
      .results_checked  (results_checked)
   );

   // Watchdog: abort a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, results_pending);
         $display("tb_xor_frame_parser_with_failsafe_top failed");
         $finish;
      end
   end

   // Result-side back-pressure: random stall bursts separated by
   // free-running stretches; drop it entirely once calm is set.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            repeat ($urandom_range(0, 15)) @(posedge clock);
         end
      end
   end

   // One register write: setup cycle, access cycle, then idle with psel low so that
   // back-to-back writes never assign psel twice in the same step.
   task automatic write_csr(input logic [1:0] index, input logic [DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Hold off new requests until every predicted result has been seen, then
   // also wait out a request that produces nothing.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_pending != 0);
      repeat (8) @(posedge clock);
   endtask

   // Reprogram all four registers on an idle block.
   task automatic apply_settings(input logic [7:0] start, input logic [7:0] ctype,
                                 input logic [LEN_W-1:0] clen,
                                 input logic [CNT_W-1:0] timeout);
      drain_results();
      write_csr(REG_START_BYTE, DATA_W'(start));
      write_csr(REG_COMMAND_TYPE, DATA_W'(ctype));
      write_csr(REG_COMMAND_LEN, DATA_W'(clen));
      write_csr(REG_TIMEOUT, DATA_W'(timeout));
      active_cfg = '{start, ctype, clen, timeout};
      settings_used++;
   endtask

   // Present one request and hold it until accepted. Valid stays high on
   // return so the next request can follow without a bubble.
   task automatic send_request(input logic func, input logic [7:0] b);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_func      <= func;
      req_data_byte <= b;
      do @(posedge clock); while (req_stall);
      requests_sent++;
      if (func == FUNC_TICK) ticks_sent++;
   endtask

   // Send a frame with random payload; ticks may fall between payload bytes.
   // Oversized lengths stop after the length byte, as the parser drops there.
   task automatic send_packet(input logic [7:0] ftype, input logic [7:0] flen,
                              input bit good_sum);
      logic [7:0] sum;
      logic [7:0] b;
      int         i;
      send_request(FUNC_BYTE, active_cfg.start_byte);
      send_request(FUNC_BYTE, ftype);
      send_request(FUNC_BYTE, flen);
      if (flen > LEN_LIMIT) return;
      sum = ftype ^ flen;
      for (i = 0; i < int'(flen); i++) begin
         b = 8'($urandom);
         sum ^= b;
         send_request(FUNC_BYTE, b);
         if ($urandom_range(0, 9) == 0) send_request(FUNC_TICK, 8'($urandom));
      end
      // corrupt exactly one checksum bit for a bad frame
      if (!good_sum) sum ^= 8'h01 << $urandom_range(0, 7);
      send_request(FUNC_BYTE, sum);
   endtask

   // Mostly well-formed frames, some aimed at the command type and length,
   // mixed with tick bursts, line noise and oversized lengths.
   task automatic send_random_event();
      int         pick;
      int         n;
      int         i;
      logic [7:0] ftype;
      logic [7:0] flen;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         n = $urandom_range(1, 3);
         for (i = 0; i < n; i++) send_request(FUNC_BYTE, 8'($urandom));
         noise_sent += n;
      end else if (pick < 22) begin
         n = $urandom_range(1, 4);
         for (i = 0; i < n; i++) send_request(FUNC_TICK, 8'($urandom));
      end else begin
         ftype = $urandom_range(0, 1) ? active_cfg.command_type : 8'($urandom);
         pick  = $urandom_range(0, 99);
         if (pick < 8)       flen = 8'($urandom_range(MAX_PAYLOAD + 1, 255));
         else if (pick < 30) flen = 8'(active_cfg.command_length);
         else if (pick < 35) flen = LEN_LIMIT;
         else if (pick < 47) flen = 8'd0;
         else                flen = 8'($urandom_range(1, 6));
         send_packet(ftype, flen, $urandom_range(0, 99) < 85);
      end
   endtask

   // Run random traffic until roughly quota meaningful requests have gone out.
   task automatic run_random(input int quota);
      int first;
      first = requests_sent - noise_sent;
      while (requests_sent - noise_sent - first < quota) send_random_event();
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_func      = FUNC_BYTE;
      req_data_byte = 8'h00;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part: all-ones start byte, type zero, length zero, and a
      // timeout of zero so the very first tick enters failsafe.
      apply_settings(8'hFF, 8'h00, '0, '0);
      send_request(FUNC_TICK, 8'hFF);   // enter failsafe
      send_request(FUNC_TICK, 8'h00);   // already in failsafe: nothing
      send_request(FUNC_BYTE, 8'h00);   // noise while hunting for start
      // empty command frame: clears failsafe
      send_request(FUNC_BYTE, 8'hFF);
      send_request(FUNC_BYTE, 8'h00);
      send_request(FUNC_BYTE, 8'h00);
      send_request(FUNC_BYTE, 8'h00);
      // length one above the maximum: reject with zero length
      send_request(FUNC_BYTE, 8'hFF);
      send_request(FUNC_BYTE, 8'hFF);
      send_request(FUNC_BYTE, LEN_LIMIT + 8'd1);
      // checksum off by one bit: reject carrying type and length
      send_request(FUNC_BYTE, 8'hFF);
      send_request(FUNC_BYTE, 8'h80);
      send_request(FUNC_BYTE, 8'h01);
      send_request(FUNC_BYTE, 8'h55);
      send_request(FUNC_BYTE, 8'hD5);
      // good two-byte frame with extreme payload values, not a command
      send_request(FUNC_BYTE, 8'hFF);
      send_request(FUNC_BYTE, 8'h00);
      send_request(FUNC_BYTE, 8'h02);
      send_request(FUNC_BYTE, 8'hFF);
      send_request(FUNC_BYTE, 8'h00);
      send_request(FUNC_BYTE, 8'hFD);
      send_request(FUNC_TICK, 8'h5A);   // failsafe again

      // Zero start byte, all-ones command type, maximum command length.
      // Drain once mid-phase so the sender waits on every outstanding result.
      apply_settings(8'h00, 8'hFF, LEN_W'(MAX_PAYLOAD), CNT_W'($urandom_range(1, 4)));
      run_random(12);
      drain_results();
      run_random(12);

      // Largest timeout: a command frame restarts the count and the ticks
      // that follow stay quiet.
      apply_settings(8'($urandom), 8'($urandom), LEN_W'($urandom_range(0, MAX_PAYLOAD)),
                     '1);
      send_packet(active_cfg.command_type, 8'(active_cfg.command_length), 1'b1);
      repeat (6) send_request(FUNC_TICK, 8'($urandom));
      run_random(15);

      // Final stretch: random settings and no idling on either side.
      apply_settings(8'($urandom), 8'($urandom), LEN_W'($urandom_range(0, MAX_PAYLOAD)),
                     CNT_W'($urandom_range(1, 6)));
      calm = 1'b1;
      run_random(20);

      drain_results();
      $display("covered %0d requests (%0d ticks, %0d noise bytes) under %0d register settings",
               requests_sent, ticks_sent, noise_sent, settings_used);
      $display("checked %0d results: payload runs, empty frames, rejects and failsafe entries",
               results_checked);
      if (mismatches == 0) begin
         $display("tb_xor_frame_parser_with_failsafe_top passed");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("tb_xor_frame_parser_with_failsafe_top failed");
      end
      $finish;
   end

endmodule
